@@ rtl/core/fvnh_pkg.sv @@
package fvnh_pkg;

  localparam int unsigned TABLE_LEN = 8;

  // octave frequency, unsigned Q5.24
  localparam logic [28:0] FREQ_Q24 [TABLE_LEN] = '{
    29'd3019899, 29'd6190793, 29'd12691125, 29'd26016806,
    29'd53334453, 29'd109335629, 29'd224138039, 29'd459482979
  };

  // octave amplitude, unsigned Q0.16
  localparam logic [15:0] AMP_Q16 [TABLE_LEN] = '{
    16'd44564, 16'd21391, 16'd10268, 16'd4928,
    16'd2366, 16'd1136, 16'd545, 16'd262
  };

  localparam logic [63:0] MIX_GOLD = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_M1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_M2   = 64'h94d049bb133111eb;

  // scaled coordinate and lattice cell widths for the widest frequency
  localparam int unsigned PX_W   = 37;
  localparam int unsigned CELL_W = 21;
  localparam int unsigned TERM_W = 52;
  localparam int unsigned ACC_W  = 55;

  localparam int unsigned OCT_STAGES  = 11;
  localparam int unsigned PIPE_STAGES = 13;

  function automatic logic [31:0] mul_lo32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

endpackage

@@ rtl/core/fvnh_octave.sv @@
module fvnh_octave #(
  parameter int unsigned K = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [fvnh_pkg::OCT_STAGES-1:0]        en_i,
  input  logic [63:0]                            seed_i,
  input  logic signed [31:0]                     coord_x_i,
  input  logic signed [31:0]                     coord_z_i,
  output logic signed [fvnh_pkg::TERM_W-1:0]     term_o
);

  localparam int unsigned PW = fvnh_pkg::PX_W;
  localparam int unsigned CW = fvnh_pkg::CELL_W;
  localparam int unsigned TW = fvnh_pkg::TERM_W;
  localparam logic [63:0] GoldK = 64'(K) * fvnh_pkg::MIX_GOLD;
  localparam logic [29:0] Freq = {1'b0, fvnh_pkg::FREQ_Q24[K]};
  localparam logic [16:0] Amp = {1'b0, fvnh_pkg::AMP_Q16[K]};
  localparam logic [31:0] M1L = fvnh_pkg::MIX_M1[31:0];
  localparam logic [31:0] M1H = fvnh_pkg::MIX_M1[63:32];
  localparam logic [31:0] M2L = fvnh_pkg::MIX_M2[31:0];
  localparam logic [31:0] M2H = fvnh_pkg::MIX_M2[63:32];

  logic [63:0] seedk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seedk_q <= GoldK;
    end else begin
      seedk_q <= seed_i + GoldK;
    end
  end

  // scale by octave frequency
  logic signed [61:0] prodx, prodz;
  logic signed [PW-1:0] px_q, pz_q;
  assign prodx = coord_x_i * $signed(Freq);
  assign prodz = coord_z_i * $signed(Freq);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      px_q <= prodx[PW+23:24];
      pz_q <= prodz[PW+23:24];
    end
  end

  // smoothstep first product and lattice hash partial products
  logic signed [CW-1:0] cx, cz;
  logic [15:0]  tx, tz;
  logic [31:0]  ttx_d, ttz_d;
  logic [17:0]  wx_d, wz_d;
  logic signed [53:0] mxl_d, mzl_d;
  logic [31:0]  mxh_d, mzh_d;
  logic [31:0]  ttx_q, ttz_q;
  logic [17:0]  wx_q, wz_q;
  logic signed [53:0] mxl_q, mzl_q;
  logic [31:0]  mxh_q, mzh_q;

  always_comb begin
    cx    = px_q[PW-1:16];
    cz    = pz_q[PW-1:16];
    tx    = px_q[15:0];
    tz    = pz_q[15:0];
    ttx_d = tx * tx;
    ttz_d = tz * tz;
    wx_d  = 18'd196608 - {1'b0, tx, 1'b0};
    wz_d  = 18'd196608 - {1'b0, tz, 1'b0};
    mxl_d = cx * $signed({1'b0, M1L});
    mzl_d = cz * $signed({1'b0, M2L});
    mxh_d = fvnh_pkg::mul_lo32({{(32-CW){cx[CW-1]}}, cx}, M1H);
    mzh_d = fvnh_pkg::mul_lo32({{(32-CW){cz[CW-1]}}, cz}, M2H);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ttx_q <= ttx_d;
      ttz_q <= ttz_d;
      wx_q  <= wx_d;
      wz_q  <= wz_d;
      mxl_q <= mxl_d;
      mzl_q <= mzl_d;
      mxh_q <= mxh_d;
      mzh_q <= mzh_d;
    end
  end

  logic [49:0] spx_d, spz_d, spx_q, spz_q;
  logic [63:0] hx_d, hz_d, hx_q, hz_q;

  always_comb begin
    spx_d = ttx_q * wx_q;
    spz_d = ttz_q * wz_q;
    hx_d  = {{10{mxl_q[53]}}, mxl_q} + {mxh_q, 32'd0};
    hz_d  = {{10{mzl_q[53]}}, mzl_q} + {mzh_q, 32'd0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      spx_q <= spx_d;
      spz_q <= spz_d;
      hx_q  <= hx_d;
      hz_q  <= hz_d;
    end
  end

  // corner index: bit 0 picks x + 1, bit 1 picks z + 1
  logic [49:0] rx, rz;
  logic [63:0] hx1, hz1;
  logic [63:0] v, u_d [4];
  logic [63:0] u_q [4];
  logic [16:0] sx_q [5];
  logic [16:0] sz_q [6];

  always_comb begin
    rx  = spx_q + 50'h0_0000_8000_0000;
    rz  = spz_q + 50'h0_0000_8000_0000;
    hx1 = hx_q + fvnh_pkg::MIX_M1;
    hz1 = hz_q + fvnh_pkg::MIX_M2;
    v   = '0;
    for (int j = 0; j < 4; j++) begin
      v      = seedk_q ^ (j[0] ? hx1 : hx_q) ^ (j[1] ? hz1 : hz_q);
      u_d[j] = v ^ (v >> 30);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      u_q     <= u_d;
      sx_q[0] <= rx[48:32];
      sz_q[0] <= rz[48:32];
    end
    for (int i = 1; i < 5; i++) begin
      if (en_i[3+i]) begin
        sx_q[i] <= sx_q[i-1];
      end
    end
    for (int i = 1; i < 6; i++) begin
      if (en_i[3+i]) begin
        sz_q[i] <= sz_q[i-1];
      end
    end
  end

  // first mixer multiply
  logic [63:0] pa_q [4];
  logic [31:0] pb_q [4], pc_q [4];

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      for (int j = 0; j < 4; j++) begin
        pa_q[j] <= u_q[j][31:0] * M1L;
        pb_q[j] <= fvnh_pkg::mul_lo32(u_q[j][31:0], M1H);
        pc_q[j] <= fvnh_pkg::mul_lo32(u_q[j][63:32], M1L);
      end
    end
  end

  logic [63:0] w_d [4], w_q [4], ws;

  always_comb begin
    ws = '0;
    for (int j = 0; j < 4; j++) begin
      ws     = pa_q[j] + {pb_q[j] + pc_q[j], 32'd0};
      w_d[j] = ws ^ (ws >> 27);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      w_q <= w_d;
    end
  end

  // second mixer multiply
  logic [63:0] qa_q [4];
  logic [31:0] qb_q [4], qc_q [4];

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      for (int j = 0; j < 4; j++) begin
        qa_q[j] <= w_q[j][31:0] * M2L;
        qb_q[j] <= fvnh_pkg::mul_lo32(w_q[j][31:0], M2H);
        qc_q[j] <= fvnh_pkg::mul_lo32(w_q[j][63:32], M2L);
      end
    end
  end

  logic [63:0] ys, yf;
  logic signed [17:0] c_d [4], c_q [4];

  always_comb begin
    ys = '0;
    yf = '0;
    for (int j = 0; j < 4; j++) begin
      ys     = qa_q[j] + {qb_q[j] + qc_q[j], 32'd0};
      yf     = ys ^ (ys >> 31);
      c_d[j] = $signed({1'b0, yf[15:0], 1'b0}) - 18'sd65535;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      c_q <= c_d;
    end
  end

  // bilinear blend along x
  logic signed [17:0] sxs, omx;
  logic signed [35:0] r0a, r0b, r1a, r1b;
  logic signed [33:0] row0_q, row1_q;

  always_comb begin
    sxs = $signed({1'b0, sx_q[4]});
    omx = 18'sd65536 - sxs;
    r0a = c_q[0] * omx;
    r0b = c_q[1] * sxs;
    r1a = c_q[2] * omx;
    r1b = c_q[3] * sxs;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      row0_q <= 34'(r0a + r0b);
      row1_q <= 34'(r1a + r1b);
    end
  end

  // blend along z
  logic signed [17:0] szs, omz;
  logic signed [50:0] b_d, b_q;

  always_comb begin
    szs = $signed({1'b0, sz_q[5]});
    omz = 18'sd65536 - szs;
    b_d = row0_q * omz + row1_q * szs;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      b_q <= b_d;
    end
  end

  // round to 2^-32 and weight by amplitude
  logic signed [50:0]  br;
  logic signed [34:0]  n;
  logic signed [TW-1:0] t_d, term_q;

  always_comb begin
    br  = b_q + 51'sd32768;
    n   = br[50:16];
    t_d = n * $signed(Amp);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[10]) begin
      term_q <= t_d;
    end
  end

  assign term_o = term_q;

endmodule

@@ rtl/core/fractal_value_noise_height.sv @@
// Fractal value-noise terrain height.
// Input channel (in_valid_i/in_ready_o) takes one coordinate pair per transaction:
// coord_x_i and coord_z_i, signed Q16.16 metres. Output channel
// (out_valid_o/out_ready_i) returns one transaction per input: height_o, signed
// Q2.14, rounded and saturated. cfg_we_i writes cfg_wdata_i into the 64-bit
// noise seed; write it only while no transaction is in flight. The datapath
// is a 13-stage pipeline: each octave unit is 11 stages (scale, smoothstep,
// two split 64-bit mixer multiplies, two blend multiplies, amplitude weight),
// then one stage sums the octaves and one rounds into the output register.
// Throughput is one transaction per cycle while out_ready_i is high. Octaves
// run side by side, so OCTAVE_COUNT sets area, not rate. Reset clears all
// valid bits and the seed to zero. When the receiver stalls, each stage holds
// only while the stage after it is full, so bubbles close up and in_ready_o
// drops only once the whole pipeline is full.
module fractal_value_noise_height #(
  parameter int unsigned OCTAVE_COUNT = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] height_o,
  input  logic               cfg_we_i,
  input  logic [63:0]        cfg_wdata_i
);

  localparam int unsigned NS = fvnh_pkg::PIPE_STAGES;
  localparam int unsigned AW = fvnh_pkg::ACC_W;

  logic [63:0]   seed_q;
  logic [NS-1:0] v_q;
  logic [NS:0]   adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  // a stage loads when it is empty or the stage after it moves
  always_comb begin
    adv[NS] = out_ready_i;
    for (int s = NS - 1; s >= 0; s--) begin
      adv[s] = !v_q[s] || adv[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NS; s++) begin
        if (adv[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  logic signed [fvnh_pkg::TERM_W-1:0] term [OCTAVE_COUNT];

  for (genvar k = 0; k < OCTAVE_COUNT; k++) begin : g_oct
    fvnh_octave #(.K(k)) u_oct (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (adv[fvnh_pkg::OCT_STAGES-1:0]),
      .seed_i    (seed_q),
      .coord_x_i (coord_x_i),
      .coord_z_i (coord_z_i),
      .term_o    (term[k])
    );
  end

  logic signed [AW-1:0] acc_d, acc_q;

  always_comb begin
    acc_d = '0;
    for (int k = 0; k < OCTAVE_COUNT; k++) begin
      acc_d = acc_d + AW'(term[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NS-2]) begin
      acc_q <= acc_d;
    end
  end

  // round half up to 2^-14 and clamp
  logic signed [AW-1:0]  hr;
  logic signed [AW-35:0] h;
  logic signed [15:0]    height_d, height_q;

  always_comb begin
    hr = acc_q + (AW'(1) <<< 33);
    h  = hr[AW-1:34];
    if (h > (AW-34)'(32767)) begin
      height_d = 16'sh7fff;
    end else if (h < -(AW-34)'(32768)) begin
      height_d = -16'sh8000;
    end else begin
      height_d = h[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NS-1]) begin
      height_q <= height_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];
  assign height_o    = height_q;

endmodule
